// File: rtl/ssbm_pkg.sv
// Shared types, widths and helpers for the shape-size barrier metric block.
package ssbm_pkg;

  localparam int unsigned MAG_W  = 64;           // magnitude of a 2x2 determinant term
  localparam int unsigned SQ_W   = 128;          // square of a magnitude
  localparam int unsigned SUM_W  = 130;          // F + Q and F + 2*D^2
  localparam int unsigned RAD_W  = SUM_W + 64;   // radicand (F + Q) * 2^64
  localparam int unsigned ROOT_W = RAD_W / 2;    // root bits, one per pipeline step
  localparam int unsigned REM_W  = ROOT_W + 3;   // partial remainder of the root
  localparam int unsigned NUM_W  = 162;          // numerator N
  localparam int unsigned DVS_W  = SQ_W + 16;    // divisor Q * 2^16
  localparam int unsigned QUO_W  = 32;           // quotient bits, top bit is overflow
  localparam int unsigned DIV_W  = DVS_W + QUO_W;

  localparam logic [31:0] METRIC_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BARRIER   = 2'd1,
    ST_SINGULAR  = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] w00;
    logic signed [31:0] w01;
    logic signed [31:0] w10;
    logic signed [31:0] w11;
  } mats_t;

  // Work handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic [MAG_W-1:0]         ud;   // |det W|
    logic [MAG_W-1:0]         up;   // |det A|
    logic [3:0][MAG_W-1:0]    mm;   // |A * adj(W)| entries
    status_e                  st;
  } job_t;

  function automatic logic [MAG_W-1:0] mag65(input logic signed [64:0] v);
    logic [64:0] n;
    n = v[64] ? (~v + 65'd1) : v;
    return n[MAG_W-1:0];
  endfunction

endpackage

// File: rtl/ssbm_if.sv
// Valid/ready channel interfaces for the metric block.
interface ssbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_r0c0;
  logic signed [31:0] a_r0c1;
  logic signed [31:0] a_r1c0;
  logic signed [31:0] a_r1c1;
  logic signed [31:0] w_r0c0;
  logic signed [31:0] w_r0c1;
  logic signed [31:0] w_r1c0;
  logic signed [31:0] w_r1c1;

  modport source (output valid, a_r0c0, a_r0c1, a_r1c0, a_r1c1,
                  w_r0c0, w_r0c1, w_r1c0, w_r1c1, input ready);
  modport sink (input valid, a_r0c0, a_r0c1, a_r1c0, a_r1c1,
                w_r0c0, w_r0c1, w_r1c0, w_r1c1, output ready);
endinterface

interface ssbm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] metric_value;
  logic [1:0]         status;

  modport source (output valid, metric_value, status, input ready);
  modport sink (input valid, metric_value, status, output ready);
endinterface

// File: rtl/ssbm_front.sv
// Front end: determinant and adjugate products, classification, magnitudes.
module ssbm_front import ssbm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  mats_t mats_i,
  output logic  job_valid_o,
  input  logic  job_ready_i,
  output job_t  job_o
);

  logic               adv;
  logic               f1_vq, f2_vq;
  logic signed [63:0] prod_d [12];
  logic signed [63:0] prod_q [12];
  logic signed [64:0] diff [6];
  job_t               job_d, job_q;

  assign adv        = !f2_vq || job_ready_i;
  assign in_ready_o = adv;

  // pairs: det W, det A, then the four entries of A * adj(W)
  always_comb begin
    prod_d[0]  = $signed(mats_i.w00) * $signed(mats_i.w11);
    prod_d[1]  = $signed(mats_i.w01) * $signed(mats_i.w10);
    prod_d[2]  = $signed(mats_i.a00) * $signed(mats_i.a11);
    prod_d[3]  = $signed(mats_i.a01) * $signed(mats_i.a10);
    prod_d[4]  = $signed(mats_i.a00) * $signed(mats_i.w11);
    prod_d[5]  = $signed(mats_i.a01) * $signed(mats_i.w10);
    prod_d[6]  = $signed(mats_i.a01) * $signed(mats_i.w00);
    prod_d[7]  = $signed(mats_i.a00) * $signed(mats_i.w01);
    prod_d[8]  = $signed(mats_i.a10) * $signed(mats_i.w11);
    prod_d[9]  = $signed(mats_i.a11) * $signed(mats_i.w10);
    prod_d[10] = $signed(mats_i.a11) * $signed(mats_i.w00);
    prod_d[11] = $signed(mats_i.a10) * $signed(mats_i.w01);
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      diff[k] = 65'(prod_q[2*k]) - 65'(prod_q[2*k+1]);
    end
    job_d.ud = mag65(diff[0]);
    job_d.up = mag65(diff[1]);
    for (int i = 0; i < 4; i++) begin
      job_d.mm[i] = mag65(diff[2+i]);
    end
    priority if (diff[0] == '0) begin
      job_d.st = ST_SINGULAR;
    end else if (diff[1] == '0 || diff[1][64] != diff[0][64]) begin
      job_d.st = ST_BARRIER;
    end else begin
      job_d.st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vq <= 1'b0;
      f2_vq <= 1'b0;
    end else if (adv) begin
      f1_vq <= in_valid_i;
      f2_vq <= f1_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 12; k++) begin
        prod_q[k] <= prod_d[k];
      end
      job_q <= job_d;
    end
  end

  assign job_valid_o = f2_vq;
  assign job_o       = job_q;

endmodule

// File: rtl/ssbm_fifo.sv
// Small queue between the front end and the arithmetic back end.
module ssbm_fifo import ssbm_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + IdxW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ssbm_back.sv
// Back end: squares, digit-serial root pipeline, 2|D|s, quotient pipeline.
module ssbm_back import ssbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [31:0] res_metric_o,
  output status_e     res_status_o
);

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hh;
  } sqpart_t;

  typedef struct packed {
    status_e            st;
    logic [MAG_W-1:0]   ud;
    logic [SUM_W-1:0]   g;
    logic [SQ_W-1:0]    q;
  } carry_t;

  logic adv;

  // square / product partials
  logic             b1_vq;
  sqpart_t          b1_sq_q [5];
  logic [63:0]      b1_pd_q [4];
  status_e          b1_st_q;
  logic [MAG_W-1:0] b1_ud_q;

  logic             b2_vq;
  logic [SQ_W-1:0]  b2_sq_q [4];
  logic [SQ_W-1:0]  b2_dd_q, b2_pd_q;
  status_e          b2_st_q;
  logic [MAG_W-1:0] b2_ud_q;

  logic             b3_vq;
  logic [SUM_W-1:0] b3_f_q;
  logic [SQ_W-1:0]  b3_q_q, b3_dd2_q;
  status_e          b3_st_q;
  logic [MAG_W-1:0] b3_ud_q;

  logic             b4_vq;
  logic [SUM_W-1:0] b4_x_q, b4_g_q;
  logic [SQ_W-1:0]  b4_q_q;
  status_e          b4_st_q;
  logic [MAG_W-1:0] b4_ud_q;

  // root pipeline, one result bit per step
  logic [ROOT_W-1:0] rt_vq;
  carry_t            rt_c_in   [ROOT_W];
  carry_t            rt_c_q    [ROOT_W];
  logic [SUM_W-1:0]  rt_x_in   [ROOT_W];
  logic [SUM_W-1:0]  rt_x_q    [ROOT_W];
  logic [ROOT_W-1:0] rt_root_in [ROOT_W];
  logic [ROOT_W-1:0] rt_root_d  [ROOT_W];
  logic [ROOT_W-1:0] rt_root_q  [ROOT_W];
  logic [REM_W-1:0]  rt_rem_in [ROOT_W];
  logic [REM_W-1:0]  rt_rem_d  [ROOT_W];
  logic [REM_W-1:0]  rt_rem_q  [ROOT_W];

  // numerator
  logic             m1_vq;
  logic [63:0]      m1_p_d [8];
  logic [63:0]      m1_p_q [8];
  carry_t           m1_c_q;
  logic             m2_vq;
  logic [NUM_W-1:0] m2_h_d [2];
  logic [NUM_W-1:0] m2_h_q [2];
  carry_t           m2_c_q;
  logic             m3_vq;
  logic [NUM_W-1:0] m3_sub_q, m3_n_q;
  logic [SQ_W-1:0]  m3_q_q;
  status_e          m3_st_q;
  logic             m4_vq;
  logic [NUM_W-1:0] m4_num_q;
  logic [DVS_W-1:0] m4_dv_q;
  status_e          m4_st_q;

  // restoring quotient pipeline
  logic [QUO_W-1:0] dq_vq;
  status_e          dq_st_in  [QUO_W];
  status_e          dq_st_q   [QUO_W];
  logic [DVS_W-1:0] dq_dv_in  [QUO_W];
  logic [DVS_W-1:0] dq_dv_q   [QUO_W];
  logic [NUM_W-1:0] dq_rem_in [QUO_W];
  logic [NUM_W-1:0] dq_rem_d  [QUO_W];
  logic [NUM_W-1:0] dq_rem_q  [QUO_W];
  logic [QUO_W-1:0] dq_quo_in [QUO_W];
  logic [QUO_W-1:0] dq_quo_d  [QUO_W];
  logic [QUO_W-1:0] dq_quo_q  [QUO_W];

  logic        res_vq;
  logic [31:0] res_metric_d, res_metric_q;
  status_e     res_st_d, res_st_q;

  sqpart_t     b1_sq_d [5];
  logic [63:0] b1_pd_d [4];
  logic [SQ_W-1:0] b2_sq_d [4];
  logic [SQ_W-1:0] b2_dd_d, b2_pd_d;

  assign adv       = !res_vq || res_ready_i;
  assign job_pop_o = adv && job_valid_i;

  function automatic sqpart_t sq_parts(input logic [63:0] v);
    sqpart_t r;
    r.ll = v[31:0] * v[31:0];
    r.lh = v[31:0] * v[63:32];
    r.hh = v[63:32] * v[63:32];
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] sq_join(input sqpart_t p);
    return {p.hh, 64'b0} + {31'b0, p.lh, 33'b0} + {64'b0, p.ll};
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b1_sq_d[i] = sq_parts(job_i.mm[i]);
    end
    b1_sq_d[4] = sq_parts(job_i.ud);
    b1_pd_d[0] = job_i.up[31:0]  * job_i.ud[31:0];
    b1_pd_d[1] = job_i.up[31:0]  * job_i.ud[63:32];
    b1_pd_d[2] = job_i.up[63:32] * job_i.ud[31:0];
    b1_pd_d[3] = job_i.up[63:32] * job_i.ud[63:32];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b2_sq_d[i] = sq_join(b1_sq_q[i]);
    end
    b2_dd_d = sq_join(b1_sq_q[4]);
    b2_pd_d = {b1_pd_q[3], 64'b0} + {32'b0, b1_pd_q[1], 32'b0}
            + {32'b0, b1_pd_q[2], 32'b0} + {64'b0, b1_pd_q[0]};
  end

  always_comb begin : root_step
    logic [RAD_W-1:0]  rad;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  tv;
    logic              ge;
    int                k;
    rt_c_in[0].st   = b4_st_q;
    rt_c_in[0].ud   = b4_ud_q;
    rt_c_in[0].g    = b4_g_q;
    rt_c_in[0].q    = b4_q_q;
    rt_x_in[0]      = b4_x_q;
    rt_root_in[0]   = '0;
    rt_rem_in[0]    = '0;
    for (int j = 1; j < ROOT_W; j++) begin
      rt_c_in[j]    = rt_c_q[j-1];
      rt_x_in[j]    = rt_x_q[j-1];
      rt_root_in[j] = rt_root_q[j-1];
      rt_rem_in[j]  = rt_rem_q[j-1];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      k     = ROOT_W - 1 - j;
      rad   = {rt_x_in[j], 64'b0};
      trial = {rt_rem_in[j], rad[2*k +: 2]};
      tv    = {{(REM_W - ROOT_W){1'b0}}, rt_root_in[j], 2'b01};
      ge    = (trial >= tv);
      rt_rem_d[j]  = ge ? REM_W'(trial - tv) : REM_W'(trial);
      rt_root_d[j] = {rt_root_in[j][ROOT_W-2:0], ge};
    end
  end

  always_comb begin : twice_ds
    logic [ROOT_W-1:0] s;
    logic [31:0]       sc;
    logic [NUM_W-1:0]  acc;
    s = rt_root_q[ROOT_W-1];
    for (int h = 0; h < 2; h++) begin
      for (int c = 0; c < 4; c++) begin
        sc = 32'(s >> (32 * c));
        m1_p_d[h*4+c] = rt_c_q[ROOT_W-1].ud[32*h +: 32] * sc;
      end
    end
    for (int h = 0; h < 2; h++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        acc = acc + (NUM_W'(m1_p_q[h*4+c]) << (32 * c));
      end
      m2_h_d[h] = acc;
    end
  end

  always_comb begin : quo_step
    logic [DIV_W-1:0] sh;
    logic             ge;
    int               k;
    dq_st_in[0]  = m4_st_q;
    dq_dv_in[0]  = m4_dv_q;
    dq_rem_in[0] = m4_num_q;
    dq_quo_in[0] = '0;
    for (int j = 1; j < QUO_W; j++) begin
      dq_st_in[j]  = dq_st_q[j-1];
      dq_dv_in[j]  = dq_dv_q[j-1];
      dq_rem_in[j] = dq_rem_q[j-1];
      dq_quo_in[j] = dq_quo_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) begin
      k  = QUO_W - 1 - j;
      sh = DIV_W'(dq_dv_in[j]) << k;
      ge = (DIV_W'(dq_rem_in[j]) >= sh);
      dq_rem_d[j] = ge ? NUM_W'(DIV_W'(dq_rem_in[j]) - sh) : dq_rem_in[j];
      dq_quo_d[j] = dq_quo_in[j];
      dq_quo_d[j][5'(k)] = ge;
    end
  end

  // quotient top bit set means the value is at least 2^31
  always_comb begin
    priority if (dq_st_q[QUO_W-1] != ST_OK) begin
      res_metric_d = '0;
      res_st_d     = dq_st_q[QUO_W-1];
    end else if (dq_quo_q[QUO_W-1][QUO_W-1]) begin
      res_metric_d = METRIC_MAX;
      res_st_d     = ST_SATURATED;
    end else begin
      res_metric_d = {1'b0, dq_quo_q[QUO_W-1][30:0]};
      res_st_d     = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vq  <= 1'b0;
      b2_vq  <= 1'b0;
      b3_vq  <= 1'b0;
      b4_vq  <= 1'b0;
      rt_vq  <= '0;
      m1_vq  <= 1'b0;
      m2_vq  <= 1'b0;
      m3_vq  <= 1'b0;
      m4_vq  <= 1'b0;
      dq_vq  <= '0;
      res_vq <= 1'b0;
    end else if (adv) begin
      b1_vq  <= job_valid_i;
      b2_vq  <= b1_vq;
      b3_vq  <= b2_vq;
      b4_vq  <= b3_vq;
      rt_vq  <= {rt_vq[ROOT_W-2:0], b4_vq};
      m1_vq  <= rt_vq[ROOT_W-1];
      m2_vq  <= m1_vq;
      m3_vq  <= m2_vq;
      m4_vq  <= m3_vq;
      dq_vq  <= {dq_vq[QUO_W-2:0], m4_vq};
      res_vq <= dq_vq[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 5; i++) begin
        b1_sq_q[i] <= b1_sq_d[i];
      end
      for (int i = 0; i < 4; i++) begin
        b1_pd_q[i] <= b1_pd_d[i];
        b2_sq_q[i] <= b2_sq_d[i];
      end
      b1_st_q <= job_i.st;
      b1_ud_q <= job_i.ud;

      b2_dd_q <= b2_dd_d;
      b2_pd_q <= b2_pd_d;
      b2_st_q <= b1_st_q;
      b2_ud_q <= b1_ud_q;

      b3_f_q   <= SUM_W'(b2_sq_q[0]) + SUM_W'(b2_sq_q[1])
                + SUM_W'(b2_sq_q[2]) + SUM_W'(b2_sq_q[3]);
      b3_q_q   <= {b2_pd_q[SQ_W-2:0], 1'b0};
      b3_dd2_q <= {b2_dd_q[SQ_W-2:0], 1'b0};
      b3_st_q  <= b2_st_q;
      b3_ud_q  <= b2_ud_q;

      b4_x_q  <= b3_f_q + SUM_W'(b3_q_q);
      b4_g_q  <= b3_f_q + SUM_W'(b3_dd2_q);
      b4_q_q  <= b3_q_q;
      b4_st_q <= b3_st_q;
      b4_ud_q <= b3_ud_q;

      for (int j = 0; j < ROOT_W; j++) begin
        rt_c_q[j]    <= rt_c_in[j];
        rt_x_q[j]    <= rt_x_in[j];
        rt_root_q[j] <= rt_root_d[j];
        rt_rem_q[j]  <= rt_rem_d[j];
      end

      for (int i = 0; i < 8; i++) begin
        m1_p_q[i] <= m1_p_d[i];
      end
      m1_c_q <= rt_c_q[ROOT_W-1];
      m2_h_q[0] <= m2_h_d[0];
      m2_h_q[1] <= m2_h_d[1];
      m2_c_q    <= m1_c_q;

      m3_sub_q <= ((m2_h_q[1] << 32) + m2_h_q[0]) << 1;
      m3_n_q   <= NUM_W'(m2_c_q.g) << 32;
      m3_q_q   <= m2_c_q.q;
      m3_st_q  <= m2_c_q.st;

      m4_num_q <= (m3_n_q >= m3_sub_q) ? m3_n_q - m3_sub_q : '0;
      m4_dv_q  <= {m3_q_q, 16'b0};
      m4_st_q  <= m3_st_q;

      for (int j = 0; j < QUO_W; j++) begin
        dq_st_q[j]  <= dq_st_in[j];
        dq_dv_q[j]  <= dq_dv_in[j];
        dq_rem_q[j] <= dq_rem_d[j];
        dq_quo_q[j] <= dq_quo_d[j];
      end

      res_metric_q <= res_metric_d;
      res_st_q     <= res_st_d;
    end
  end

  assign res_valid_o  = res_vq;
  assign res_metric_o = res_metric_q;
  assign res_status_o = res_st_q;

endmodule

// File: rtl/shape_size_barrier_metric_2x2.sv
// Top level of the 2x2 shape-size barrier metric block.
//
//  channel  dir  handshake    payload
//  in_i     in   valid/ready  a_r0c0..a_r1c1, w_r0c0..w_r1c1 (signed Q16.16)
//  out_o    out  valid/ready  metric_value (signed Q16.16), status (2 bits)
//
// One item per cycle sustained while the output is not stalled; the square root
// pipeline has 97 steps and the quotient pipeline 32 steps.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.
// A stalled output freezes the back end; the front end keeps accepting until
// the queue between them fills.
module shape_size_barrier_metric_2x2 import ssbm_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssbm_in_if.sink     in_i,
  ssbm_out_if.source  out_o
);

  mats_t   mats;
  logic    job_valid;
  job_t    job_front, job_back;
  logic    fifo_full, fifo_empty;
  logic    job_push, job_pop;
  logic [31:0] res_metric;
  status_e res_status;
  logic    res_valid;

  assign mats.a00 = in_i.a_r0c0;
  assign mats.a01 = in_i.a_r0c1;
  assign mats.a10 = in_i.a_r1c0;
  assign mats.a11 = in_i.a_r1c1;
  assign mats.w00 = in_i.w_r0c0;
  assign mats.w01 = in_i.w_r0c1;
  assign mats.w10 = in_i.w_r1c0;
  assign mats.w11 = in_i.w_r1c1;

  ssbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .mats_i      (mats),
    .job_valid_o (job_valid),
    .job_ready_i (!fifo_full),
    .job_o       (job_front)
  );

  assign job_push = job_valid && !fifo_full;

  ssbm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_front),
    .full_o  (fifo_full),
    .pop_i   (job_pop),
    .empty_o (fifo_empty),
    .data_o  (job_back)
  );

  ssbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!fifo_empty),
    .job_i        (job_back),
    .job_pop_o    (job_pop),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .res_metric_o (res_metric),
    .res_status_o (res_status)
  );

  assign out_o.valid        = res_valid;
  assign out_o.metric_value = res_metric;
  assign out_o.status       = res_status;

`ifndef SYNTH
  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !job_pop)
    else $error("queue popped while output stalled");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_SATURATED) |-> (out_o.metric_value == METRIC_MAX))
    else $error("saturated result without max value");

  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_full && job_valid) |-> !in_i.ready)
    else $error("input ready while queue full and front end holding work");
`endif

endmodule

// File: tb/shape_size_barrier_metric_2x2_tb.sv
// Testbench for the 2x2 shape-size barrier metric block: predicted results vs. the outputs.
module shape_size_barrier_metric_2x2_tb;
  import ssbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 300;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] metric;
    status_e            st;
  } metric_t;

  logic clk_i;
  logic rst_ni;
  ssbm_in_if  in_if ();
  ssbm_out_if out_if ();

  shape_size_barrier_metric_2x2 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  metric_t     expected_q[$];
  int unsigned n_errors;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cnt;
  bit          hold_req;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // out_if.ready is driven only by the receiver process below.
  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    {in_if.a_r0c0, in_if.a_r0c1, in_if.a_r1c0, in_if.a_r1c1} <= '0;
    {in_if.w_r0c0, in_if.w_r0c1, in_if.w_r1c0, in_if.w_r1c1} <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [255:0] abs66(input logic signed [65:0] v);
    logic [65:0] u;
    u = v[65] ? -v : v;
    return 256'(u);
  endfunction

  // Exact wide-integer evaluation of the barrier metric.
  function automatic metric_t predict_metric(input mats_t m);
    logic signed [65:0] det_w, det_a;
    logic signed [65:0] adj [4];
    logic [255:0] ud, up, frob, q2, dd, rad, root, cand, num, sub, quo;
    metric_t r;
    det_w = m.w00 * m.w11 - m.w01 * m.w10;
    det_a = m.a00 * m.a11 - m.a01 * m.a10;
    r.metric = '0;
    if (det_w == 0) begin
      r.st = ST_SINGULAR;
      return r;
    end
    if (det_a == 0 || det_a[65] != det_w[65]) begin
      r.st = ST_BARRIER;
      return r;
    end
    adj[0] = m.a00 * m.w11 - m.a01 * m.w10;
    adj[1] = m.a01 * m.w00 - m.a00 * m.w01;
    adj[2] = m.a10 * m.w11 - m.a11 * m.w10;
    adj[3] = m.a11 * m.w00 - m.a10 * m.w01;
    ud = abs66(det_w);
    up = abs66(det_a);
    q2 = (up * ud) << 1;
    frob = '0;
    for (int i = 0; i < 4; i++) frob += abs66(adj[i]) * abs66(adj[i]);
    dd = ud * ud;
    rad = (frob + q2) << 64;
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (256'd1 << i);
      if (cand * cand <= rad) root = cand;
    end
    num = (frob + (dd << 1)) << 32;
    sub = (ud * root) << 1;
    num = (num < sub) ? '0 : num - sub;
    quo = (num << 16) / (q2 << 32);
    if (quo > 256'h7FFF_FFFF) begin
      r.metric = METRIC_MAX;
      r.st = ST_SATURATED;
    end else begin
      r.metric = quo[31:0];
      r.st = ST_OK;
    end
    return r;
  endfunction

  task automatic send_mats(input mats_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.a_r0c0 <= m.a00;
    in_if.a_r0c1 <= m.a01;
    in_if.a_r1c0 <= m.a10;
    in_if.a_r1c1 <= m.a11;
    in_if.w_r0c0 <= m.w00;
    in_if.w_r0c1 <= m.w01;
    in_if.w_r1c0 <= m.w10;
    in_if.w_r1c1 <= m.w11;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(predict_metric(m));
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] c, input int unsigned r);
    return c + $signed(32'($urandom_range(2 * r))) - $signed(32'(r));
  endfunction

  function automatic mats_t random_mats();
    mats_t m;
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // Elements near a scaled identity give in-range metric values.
      m.w00 = near(ONE, 40000);
      m.w11 = near(ONE, 40000);
      m.w01 = near(0, 20000);
      m.w10 = near(0, 20000);
      m.a00 = near(ONE, 60000);
      m.a11 = near(ONE, 60000);
      m.a01 = near(0, 30000);
      m.a10 = near(0, 30000);
      if (kind == 9) begin
        m.a00 = -m.a00;
        m.a11 = m.a11 <<< $urandom_range(6);
      end
    end
    return m;
  endfunction

  task automatic test_directed();
    mats_t m;
    m = '{ONE, 0, 0, ONE, ONE, 0, 0, ONE};          send_mats(m);  // identity, zero metric
    m = '{2 * ONE, 0, 0, ONE, ONE, 0, 0, ONE};      send_mats(m);
    m = '{ONE, ONE, 0, ONE, ONE, 0, 0, ONE};        send_mats(m);  // shear
    m = '{-ONE, 0, 0, -ONE, ONE, 0, 0, ONE};        send_mats(m);  // rotation by pi
    m = '{ONE, 0, 0, ONE, 0, 0, 0, 0};              send_mats(m);  // singular target
    m = '{ONE, ONE, ONE, ONE, ONE, 0, 0, ONE};      send_mats(m);  // zero det A
    m = '{-ONE, 0, 0, ONE, ONE, 0, 0, ONE};         send_mats(m);  // inverted
    m = '{-ONE, 0, 0, ONE, -ONE, 0, 0, ONE};        send_mats(m);  // both negative
    m = '{SMAX, 0, 0, 1, ONE, 0, 0, ONE};           send_mats(m);  // saturates
    m = '{1, 0, 0, 1, SMAX, 0, 0, SMAX};            send_mats(m);
    m = '{SMIN, 0, 0, SMIN, SMIN, 0, 0, SMIN};      send_mats(m);
    m = '{SMIN, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, SMAX}; send_mats(m);
    m = '{SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN, SMIN}; send_mats(m);
    m = '{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN}; send_mats(m);
    m = '{-1, -1, 1, -1, -1, 1, -1, -1};            send_mats(m);
    m = '{ONE, 0, 0, ONE, 0, ONE, ONE, 0};          send_mats(m);  // negative det W
    m = '{0, ONE, ONE, 0, 0, ONE, ONE, 0};          send_mats(m);
    m = '{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX}; send_mats(m);
    m = '{SMIN, 0, 0, SMIN, 1, 0, 0, 1};            send_mats(m);
    end_burst();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned idle,
                             input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_mats(random_mats());
    end_burst();
  endtask

  // More items than the pipeline and queue can hold, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) send_mats(random_mats());
    end_burst();
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      hold_req <= 1'b0;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= (hold_cnt == 1);
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    metric_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: metric_value %h status %0d",
               out_if.metric_value, out_if.status);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.metric_value !== exp_r.metric) begin
          $error("metric_value: expected %h, actual %h", exp_r.metric, out_if.metric_value);
          n_errors++;
        end
        if (out_if.status !== exp_r.st) begin
          $error("status: expected %0d, actual %0d", exp_r.st, out_if.status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    n_errors = 0;
    cycle_cnt = 0;
    hold_cnt = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_random(120, 0, 0);
    test_random(150, 68, 0);
    test_random(150, 0, 68);
    test_random(110, 19, 19);
    test_backpressure();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ssbm_pkg.sv
rtl/ssbm_if.sv
rtl/ssbm_front.sv
rtl/ssbm_fifo.sv
rtl/ssbm_back.sv
rtl/shape_size_barrier_metric_2x2.sv
tb/shape_size_barrier_metric_2x2_tb.sv
